FILE: rtl/sas_pkg.sv
// Shared types, widths, codes and defaults of the sprite animation sequencer.
package sas_pkg;

    // Field widths of the beats on the item, result and configuration channels.
    localparam int CMD_W    = 2;
    localparam int DELTA_W  = 16;
    localparam int ID_W     = 4;
    localparam int SLOT_W   = 4;
    localparam int TILE_W   = 12;
    localparam int DUR_W    = 16;
    localparam int COUNT_W  = 5;
    localparam int REP_W    = 8;
    localparam int COORD_W  = 24;
    localparam int FRAME_W  = 4;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 2;

    // Width of the shared divider.
    localparam int DIV_W = 13;

    // Parameter defaults.
    localparam int NUM_ANIMS_DEF  = 8;
    localparam int MAX_FRAMES_DEF = 16;

    // Item commands.
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FRAME   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ANIM    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT   = 2'd2;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] TEXTURE_WIDTH_RST = 13'd256;
    localparam logic [CFG_W-1:0] CELL_WIDTH_RST    = 13'd32;
    localparam logic [CFG_W-1:0] CELL_HEIGHT_RST   = 13'd32;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [DELTA_W-1:0] delta;
        logic [ID_W-1:0]    anim_id;
        logic [SLOT_W-1:0]  frame_slot;
        logic [TILE_W-1:0]  tile_index;
        logic [DUR_W-1:0]   duration;
        logic [COUNT_W-1:0] frame_count;
        logic [REP_W-1:0]   repeats;
        logic [ID_W-1:0]    next_anim;
        logic               allow_interrupt;
    } item_t;

    typedef struct packed {
        logic [COORD_W-1:0] src_x;
        logic [COORD_W-1:0] src_y;
        logic               active;
        logic [ID_W-1:0]    current_anim;
        logic [FRAME_W-1:0] current_frame;
    } result_t;

    // One entry of the frame table.
    typedef struct packed {
        logic [TILE_W-1:0] tile;
        logic [DUR_W-1:0]  duration;
    } frame_entry_t;

    // Request to and response from the shared divider.
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } div_rsp_t;

endpackage

FILE: rtl/sas_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module sas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/sas_div.sv
// Iterative restoring divider, one quotient bit per cycle, shared by all divisions.
module sas_div (
    input  logic              clk,
    input  logic              rst_n,
    input  sas_pkg::div_req_t req,
    output sas_pkg::div_rsp_t rsp
);

    localparam int W     = sas_pkg::DIV_W;
    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [W:0]   shifted;
    logic [W+1:0] trial;
    logic         fits;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};
    assign fits    = ~trial[W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[W-1:0] : shifted[W-1:0];
            quo_reg <= {quo_reg[W-2:0], fits};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: rtl/sprite_animation_sequencer.sv
// Top level of the sprite animation sequencer: command decode, playback sequencer, tile math.
//
//  Channel  Signals                                   Beat contents
//  -------  ----------------------------------------  -----------------------------------
//  item     item_valid, item_ready, item              command, timing and table fields
//  result   result_valid, result_ready, result        sheet source x/y and playback state
//  cfg      cfg_valid, cfg_ready, cfg_index, cfg_data texture width, cell width/height
//
// Write and request commands finish in the cycle they are accepted; their result beat is
// registered at that edge. A tick walks a small sequencer over the two table memories.
// When a frame is loaded the shared 13-bit divider splits the tile into column and row
// and one multiplier scales both; after a configuration write the first load also
// recomputes the column count with the same divider.
// Reset clears the animation table valid bits and all playback state at once; the frame
// table holds whatever it held until written. A result beat waits in its output register
// while result_ready is low, and no new item is taken until that register can be refilled.
module sprite_animation_sequencer #(
    parameter int NUM_ANIMS  = sas_pkg::NUM_ANIMS_DEF,
    parameter int MAX_FRAMES = sas_pkg::MAX_FRAMES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  sas_pkg::item_t                     item,
    output logic                               result_valid,
    input  logic                               result_ready,
    output sas_pkg::result_t                   result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sas_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sas_pkg::CFG_W-1:0]          cfg_data
);

    // Animation address bits, animation index bits (room for the "none" code),
    // frame position bits and frame count bits.
    localparam int AAW    = (NUM_ANIMS > 1) ? $clog2(NUM_ANIMS) : 1;
    localparam int AIW    = $clog2(NUM_ANIMS + 1);
    localparam int FW     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW     = $clog2(MAX_FRAMES + 1);
    localparam int RW     = sas_pkg::REP_W;
    localparam int AEW    = CW + RW + AIW + 1;
    localparam int FAW    = AAW + FW;
    localparam int FDEPTH = 1 << FAW;
    localparam int TW     = sas_pkg::TILE_W;
    localparam int DW     = sas_pkg::DUR_W;
    localparam int XW     = sas_pkg::COORD_W;
    localparam int MW     = TW + sas_pkg::CFG_W;

    localparam logic [AIW-1:0] ANIM_NONE = AIW'(NUM_ANIMS);

    typedef enum logic [13:0] {
        ST_IDLE    = 14'b00000000000001,
        ST_PLAY_RD = 14'b00000000000010,
        ST_PEND_RD = 14'b00000000000100,
        ST_SWITCH  = 14'b00000000001000,
        ST_ENT     = 14'b00000000010000,
        ST_ADV     = 14'b00000000100000,
        ST_LOAD_RD = 14'b00000001000000,
        ST_LOAD    = 14'b00000010000000,
        ST_SRC     = 14'b00000100000000,
        ST_COLS    = 14'b00001000000000,
        ST_TDIV    = 14'b00010000000000,
        ST_MULX    = 14'b00100000000000,
        ST_MULY    = 14'b01000000000000,
        ST_FINISH  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [sas_pkg::CFG_W-1:0] tex_w_reg, cell_w_reg, cell_h_reg;

    // Playback state.
    logic [AIW-1:0] playing_reg, playing_next;
    logic [AIW-1:0] pending_reg, pending_next;
    logic [FW-1:0]  frame_pos_reg, frame_pos_next;
    logic [RW-1:0]  loop_reg, loop_next;
    logic [DW-1:0]  time_left_reg, time_left_next;
    logic [XW-1:0]  src_x_reg, src_x_next;
    logic [XW-1:0]  src_y_reg, src_y_next;

    // Working registers of one tick.
    logic [sas_pkg::DELTA_W-1:0] delta_reg, delta_next;
    logic                        eligible_reg, eligible_next;
    logic                        switched_reg, switched_next;
    logic [AIW-1:0]              load_anim_reg, load_anim_next;
    logic [TW-1:0]               tile_reg, tile_next;

    // Cached column count of the sheet; a configuration write invalidates it.
    logic [sas_pkg::DIV_W-1:0] cols_reg, cols_next;
    logic                      cols_ok_reg, cols_ok_next;

    // Result output register.
    logic             result_valid_reg, result_valid_next;
    sas_pkg::result_t result_reg;
    logic             result_load;

    logic item_accept;
    logic id_ok;
    logic next_ok;

    // Animation table: a RAM plus one valid bit per entry; an invalid entry reads as zero.
    logic [NUM_ANIMS-1:0] anim_valid_reg;
    logic                 anim_wr_en;
    logic [AEW-1:0]       anim_wr_data;
    logic [AIW-1:0]       anim_rd_sel;
    logic [AEW-1:0]       anim_rd_data;
    logic                 anim_vld_rd_reg;
    logic [CW-1:0]        ent_count;
    logic [RW-1:0]        ent_repeats;
    logic [AIW-1:0]       ent_next;
    logic                 ent_intr;
    logic [CW-1:0]        wr_count;

    // Frame table.
    logic                  frame_wr_en;
    logic [FAW-1:0]        frame_rd_addr;
    sas_pkg::frame_entry_t frame_wr_data;
    sas_pkg::frame_entry_t frame_rd_data;

    // Shared divider and multiplier.
    sas_pkg::div_req_t div_req;
    sas_pkg::div_rsp_t div_rsp;
    logic [TW-1:0]             mul_a;
    logic [sas_pkg::CFG_W-1:0] mul_b;
    logic [MW-1:0]             mul_p;

    // Frame time countdown.
    logic [DW-1:0] tl_cur;
    logic [DW:0]   tl_diff;
    logic          tl_alive;

    //--------------------------------------------------------------------------
    // Handshakes.
    //--------------------------------------------------------------------------
    assign cfg_ready   = 1'b1;
    assign item_ready  = (state_reg == ST_IDLE) && (!result_valid_reg || result_ready);
    assign item_accept = item_valid && item_ready;

    // Non-tick commands answer right away; a tick answers from its last state.
    assign result_load = (item_accept && (item.cmd != sas_pkg::CMD_TICK)) ||
                         ((state_reg == ST_FINISH) && (!result_valid_reg || result_ready));

    assign id_ok   = int'(item.anim_id) < NUM_ANIMS;
    assign next_ok = int'(item.next_anim) < NUM_ANIMS;

    //--------------------------------------------------------------------------
    // Table writes come straight from an accepted item beat.
    //--------------------------------------------------------------------------
    assign frame_wr_en = item_accept && (item.cmd == sas_pkg::CMD_FRAME) && id_ok &&
                         (int'(item.frame_slot) < MAX_FRAMES);
    assign frame_wr_data.tile     = item.tile_index;
    assign frame_wr_data.duration = item.duration;

    assign anim_wr_en = item_accept && (item.cmd == sas_pkg::CMD_ANIM) && id_ok;
    assign wr_count   = (int'(item.frame_count) > MAX_FRAMES) ? CW'(MAX_FRAMES)
                                                             : CW'(item.frame_count);
    assign anim_wr_data = {wr_count, item.repeats,
                           next_ok ? AIW'(item.next_anim) : ANIM_NONE,
                           item.allow_interrupt};

    // The pending animation is read only while deciding whether to switch to it.
    assign anim_rd_sel = (state_reg == ST_PEND_RD) ? pending_reg : playing_reg;

    assign frame_rd_addr = (state_reg == ST_LOAD_RD) ? {load_anim_reg[AAW-1:0], frame_pos_reg}
                                                     : {playing_reg[AAW-1:0], frame_pos_reg};

    sas_ram #(
        .WIDTH (AEW),
        .DEPTH (NUM_ANIMS)
    ) u_anim_ram (
        .clk     (clk),
        .wr_en   (anim_wr_en),
        .wr_addr (AAW'(item.anim_id)),
        .wr_data (anim_wr_data),
        .rd_addr (anim_rd_sel[AAW-1:0]),
        .rd_data (anim_rd_data)
    );

    sas_ram #(
        .WIDTH ($bits(sas_pkg::frame_entry_t)),
        .DEPTH (FDEPTH)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (frame_wr_en),
        .wr_addr ({AAW'(item.anim_id), FW'(item.frame_slot)}),
        .wr_data (frame_wr_data),
        .rd_addr (frame_rd_addr),
        .rd_data (frame_rd_data)
    );

    // Entry fields, forced to the cleared value when the entry was never written.
    assign ent_intr    = anim_vld_rd_reg & anim_rd_data[0];
    assign ent_next    = anim_vld_rd_reg ? anim_rd_data[AIW:1] : '0;
    assign ent_repeats = anim_vld_rd_reg ? anim_rd_data[AIW+RW:AIW+1] : '0;
    assign ent_count   = anim_vld_rd_reg ? anim_rd_data[AEW-1:AIW+RW+1] : '0;

    //--------------------------------------------------------------------------
    // Shared arithmetic.
    //--------------------------------------------------------------------------
    // With the column count cached the divider splits the tile; otherwise it first
    // divides the texture width by the cell width.
    assign div_req.start    = (state_reg == ST_SRC);
    assign div_req.dividend = cols_ok_reg ? sas_pkg::DIV_W'(tile_reg) : tex_w_reg;
    assign div_req.divisor  = cols_ok_reg ? cols_reg : cell_w_reg;

    sas_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // One multiplier scales the column by the cell width, then the row by the cell height.
    assign mul_a = (state_reg == ST_MULX) ? div_rsp.remainder[TW-1:0]
                                          : div_rsp.quotient[TW-1:0];
    assign mul_b = (state_reg == ST_MULX) ? cell_w_reg : cell_h_reg;
    assign mul_p = MW'(mul_a) * MW'(mul_b);

    // A freshly switched animation counts from its first frame's time.
    assign tl_cur   = switched_reg ? frame_rd_data.duration : time_left_reg;
    assign tl_diff  = {1'b0, tl_cur} - {1'b0, delta_reg};
    assign tl_alive = !tl_diff[DW] && (tl_diff[DW-1:0] != '0);

    //--------------------------------------------------------------------------
    // Sequencer.
    //--------------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        playing_next   = playing_reg;
        pending_next   = pending_reg;
        frame_pos_next = frame_pos_reg;
        loop_next      = loop_reg;
        time_left_next = time_left_reg;
        src_x_next     = src_x_reg;
        src_y_next     = src_y_reg;
        delta_next     = delta_reg;
        eligible_next  = eligible_reg;
        switched_next  = switched_reg;
        load_anim_next = load_anim_reg;
        tile_next      = tile_reg;
        cols_next      = cols_reg;
        cols_ok_next   = cols_ok_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    if (item.cmd == sas_pkg::CMD_TICK)
                    begin
                        delta_next    = item.delta;
                        switched_next = 1'b0;
                        state_next    = ST_PLAY_RD;
                    end
                    else if (item.cmd == sas_pkg::CMD_REQUEST)
                    begin
                        pending_next = id_ok ? AIW'(item.anim_id) : ANIM_NONE;
                    end
                end
            end
            ST_PLAY_RD:
            begin
                state_next = ST_PEND_RD;
            end
            ST_PEND_RD:
            begin
                // A request is taken up when idle, when interruption is allowed, or at
                // the first frame.
                eligible_next = (playing_reg == ANIM_NONE) || ent_intr ||
                                (frame_pos_reg == '0);
                state_next    = ST_SWITCH;
            end
            ST_SWITCH:
            begin
                if (eligible_reg)
                begin
                    if ((pending_reg != ANIM_NONE) && (ent_count != '0))
                    begin
                        playing_next   = pending_reg;
                        frame_pos_next = '0;
                        loop_next      = '0;
                        switched_next  = 1'b1;
                    end
                    pending_next = ANIM_NONE;
                end
                state_next = ST_ENT;
            end
            ST_ENT:
            begin
                state_next = (playing_reg == ANIM_NONE) ? ST_FINISH : ST_ADV;
            end
            ST_ADV:
            begin
                if (tl_alive)
                begin
                    time_left_next = tl_diff[DW-1:0];
                    if (switched_reg)
                    begin
                        tile_next  = frame_rd_data.tile;
                        state_next = ST_SRC;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else
                begin
                    load_anim_next = playing_reg;
                    if ((CW'(frame_pos_reg) + CW'(1)) < ent_count)
                    begin
                        frame_pos_next = frame_pos_reg + FW'(1);
                    end
                    else
                    begin
                        // End of a loop: wrap, count the loop, or stop and chain.
                        frame_pos_next = '0;
                        if (loop_reg < ent_repeats)
                        begin
                            loop_next = loop_reg + RW'(1);
                        end
                        else if (ent_repeats != '0)
                        begin
                            if (pending_reg == ANIM_NONE)
                            begin
                                pending_next = ent_next;
                            end
                            playing_next = ANIM_NONE;
                            loop_next    = '0;
                        end
                    end
                    state_next = ST_LOAD_RD;
                end
            end
            ST_LOAD_RD:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                time_left_next = frame_rd_data.duration;
                tile_next      = frame_rd_data.tile;
                state_next     = ST_SRC;
            end
            ST_SRC:
            begin
                state_next = cols_ok_reg ? ST_TDIV : ST_COLS;
            end
            ST_COLS:
            begin
                if (div_rsp.done)
                begin
                    // A zero cell width or a sheet narrower than a cell gives one column.
                    if ((cell_w_reg == '0) || (div_rsp.quotient == '0))
                    begin
                        cols_next = sas_pkg::DIV_W'(1);
                    end
                    else
                    begin
                        cols_next = div_rsp.quotient;
                    end
                    cols_ok_next = 1'b1;
                    state_next   = ST_SRC;
                end
            end
            ST_TDIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_MULX;
                end
            end
            ST_MULX:
            begin
                src_x_next = mul_p[XW-1:0];
                state_next = ST_MULY;
            end
            ST_MULY:
            begin
                src_y_next = mul_p[XW-1:0];
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid)
        begin
            cols_ok_next = 1'b0;
        end
    end

    always_comb
    begin
        if (result_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    //--------------------------------------------------------------------------
    // Registers.
    //--------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            tex_w_reg        <= sas_pkg::TEXTURE_WIDTH_RST;
            cell_w_reg       <= sas_pkg::CELL_WIDTH_RST;
            cell_h_reg       <= sas_pkg::CELL_HEIGHT_RST;
            playing_reg      <= ANIM_NONE;
            pending_reg      <= ANIM_NONE;
            frame_pos_reg    <= '0;
            loop_reg         <= '0;
            time_left_reg    <= '0;
            src_x_reg        <= '0;
            src_y_reg        <= '0;
            eligible_reg     <= 1'b0;
            switched_reg     <= 1'b0;
            cols_ok_reg      <= 1'b0;
            anim_valid_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            playing_reg      <= playing_next;
            pending_reg      <= pending_next;
            frame_pos_reg    <= frame_pos_next;
            loop_reg         <= loop_next;
            time_left_reg    <= time_left_next;
            src_x_reg        <= src_x_next;
            src_y_reg        <= src_y_next;
            eligible_reg     <= eligible_next;
            switched_reg     <= switched_next;
            cols_ok_reg      <= cols_ok_next;
            result_valid_reg <= result_valid_next;
            if (anim_wr_en)
            begin
                anim_valid_reg[AAW'(item.anim_id)] <= 1'b1;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    sas_pkg::CFG_TEXTURE_WIDTH: tex_w_reg  <= cfg_data;
                    sas_pkg::CFG_CELL_WIDTH:    cell_w_reg <= cfg_data;
                    sas_pkg::CFG_CELL_HEIGHT:   cell_h_reg <= cfg_data;
                    default:                    tex_w_reg  <= tex_w_reg;
                endcase
            end
        end
    end

    // Working values that need no reset.
    always_ff @(posedge clk)
    begin
        delta_reg       <= delta_next;
        load_anim_reg   <= load_anim_next;
        tile_reg        <= tile_next;
        cols_reg        <= cols_next;
        anim_vld_rd_reg <= (anim_rd_sel != ANIM_NONE) && anim_valid_reg[anim_rd_sel[AAW-1:0]];
        if (result_load)
        begin
            result_reg.src_x         <= src_x_reg;
            result_reg.src_y         <= src_y_reg;
            result_reg.active        <= (playing_reg != ANIM_NONE);
            result_reg.current_anim  <= sas_pkg::ID_W'(playing_reg);
            result_reg.current_frame <= sas_pkg::FRAME_W'(frame_pos_reg);
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_playing_range: assert property (@(posedge clk) disable iff (!rst_n)
        playing_reg <= ANIM_NONE)
        else $error("playing animation index beyond the none code");

    a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= ANIM_NONE)
        else $error("pending animation index beyond the none code");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(frame_pos_reg) < MAX_FRAMES)
        else $error("frame position beyond the frame table row");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_COLS || state_reg == ST_TDIV))
        else $error("divider finished while the sequencer was not waiting for it");

    a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) && !result_valid_reg |=>
            (state_reg == ST_IDLE) && result_valid_reg)
        else $error("finished tick did not produce its result beat");
`endif

endmodule
